// ===== rtl/core/wavg_pkg.sv =====
// wavg_pkg: shared constants and types for the window average block
// no dependencies
package wavg_pkg;
	localparam int WINDOW_MAX  = 256;
	localparam int SAMPLE_BITS = 16;
	localparam int AVG_BITS    = 24;
	localparam int CNT_BITS    = 32;
	localparam int LSUM_BITS   = 48;
	localparam int WLEN_BITS   = 16;
	localparam int WLEN_RESET  = 16;
	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;
	localparam int REG_WINDOW_LENGTH = 0;

	typedef struct packed {
		logic clear;
		logic store;
		logic scan_start;
		logic scan_step;
		logic div_start;
		logic [1:0] div_sel;
		logic div_capture;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
	} status_t;
endpackage

// ===== rtl/core/window_average_with_quarter_sums.sv =====
// window_average_with_quarter_sums: top level, apb register, controller, datapath
// depends on wavg_pkg, wavg_ctrl, wavg_datapath
//  channel | handshake             | word
//  in      | in_valid / in_ready   | operation, sample
//  out     | out_valid / out_ready | four Q.8 averages
//  cfg     | psel/penable/pwrite   | window_length
// one item: an accept, then a ring scan over the filled entries (one memory read port),
// then four divisions in turn on one shared divider
// reset clears counters and sums; the ring needs no clearing
// a clear item returns zeros in the cycle after it is accepted; output stalls hold the block
module window_average_with_quarter_sums #(
	parameter int WINDOW_MAX  = wavg_pkg::WINDOW_MAX,
	parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic operation,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [wavg_pkg::AVG_BITS-1:0] window_avg,
	output logic signed [wavg_pkg::AVG_BITS-1:0] lifetime_avg,
	output logic signed [wavg_pkg::AVG_BITS-1:0] newest_quarter_avg,
	output logic signed [wavg_pkg::AVG_BITS-1:0] oldest_quarter_avg,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [wavg_pkg::WLEN_BITS-1:0] wlen_q;
	wavg_pkg::cmd_t cmd;
	wavg_pkg::status_t status;

	assign pready = 1'b1;
	assign prdata = (paddr[1:0] == 2'(wavg_pkg::REG_WINDOW_LENGTH))
		? {16'd0, wlen_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wlen_q <= wavg_pkg::WLEN_BITS'(wavg_pkg::WLEN_RESET);
		else if (psel && penable && pwrite && paddr == 2'(wavg_pkg::REG_WINDOW_LENGTH))
			wlen_q <= pwdata[wavg_pkg::WLEN_BITS-1:0];
	end

	wavg_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .cmd(cmd)
	);

	wavg_datapath #(.WINDOW_MAX(WINDOW_MAX), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status), .sample(sample),
		.wlen(wlen_q), .window_avg(window_avg), .lifetime_avg(lifetime_avg),
		.newest_quarter_avg(newest_quarter_avg), .oldest_quarter_avg(oldest_quarter_avg)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(window_avg))
		else $error("result dropped");
endmodule

// ===== rtl/core/wavg_divider.sv =====
// wavg_divider: signed restoring divider, one quotient bit per cycle, saturated
// depends on wavg_pkg
module wavg_divider #(
	parameter int NUM_BITS = 64,
	parameter int DEN_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [NUM_BITS-1:0]        num,
	input  logic        [DEN_BITS-1:0]        den,
	output logic                              done,
	output logic signed [wavg_pkg::AVG_BITS-1:0] quot
);
	localparam int CW = $clog2(NUM_BITS + 1);
	logic [NUM_BITS-1:0] q_q;
	logic [DEN_BITS:0]   r_q;
	logic [DEN_BITS-1:0] d_q;
	logic                neg_q, zero_q, busy_q;
	logic [CW-1:0]       cnt_q;
	logic [DEN_BITS:0]   trial;
	logic [DEN_BITS+1:0] shifted;
	logic [NUM_BITS-1:0] mag;
	logic signed [NUM_BITS:0] sq;

	assign shifted = {r_q, q_q[NUM_BITS-1]};
	assign trial   = shifted[DEN_BITS:0] - {1'b0, d_q};
	assign mag     = num[NUM_BITS-1] ? (~num + 1'b1) : num;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= mag;
			r_q    <= '0;
			d_q    <= den;
			neg_q  <= num[NUM_BITS-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			if (shifted[DEN_BITS+1] || !trial[DEN_BITS]) begin
				r_q <= shifted[DEN_BITS:0] - {1'b0, d_q};
				q_q <= {q_q[NUM_BITS-2:0], 1'b1};
			end else begin
				r_q <= shifted[DEN_BITS:0];
				q_q <= {q_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		sq = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
		if (zero_q)
			quot = '0;
		else if (sq > $signed((NUM_BITS+1)'(8388607)))
			quot = 24'sh7fffff;
		else if (sq < -$signed((NUM_BITS+1)'(8388608)))
			quot = 24'sh800000;
		else
			quot = sq[wavg_pkg::AVG_BITS-1:0];
	end
endmodule

// ===== rtl/core/wavg_datapath.sv =====
// wavg_datapath: sample ring, sums, counters, window scan and result registers
// depends on wavg_pkg, wavg_divider
module wavg_datapath #(
	parameter int WINDOW_MAX  = wavg_pkg::WINDOW_MAX,
	parameter int SAMPLE_BITS = wavg_pkg::SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wavg_pkg::cmd_t                cmd,
	output wavg_pkg::status_t             status,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [wavg_pkg::WLEN_BITS-1:0] wlen,
	output logic signed [wavg_pkg::AVG_BITS-1:0] window_avg,
	output logic signed [wavg_pkg::AVG_BITS-1:0] lifetime_avg,
	output logic signed [wavg_pkg::AVG_BITS-1:0] newest_quarter_avg,
	output logic signed [wavg_pkg::AVG_BITS-1:0] oldest_quarter_avg
);
	localparam int AW = $clog2(WINDOW_MAX);
	localparam int LW = AW + 1;
	localparam int WSB = SAMPLE_BITS + LW;
	localparam int CB = wavg_pkg::CNT_BITS;
	localparam int LB = wavg_pkg::LSUM_BITS;
	localparam int NB = LB + 9;

	logic signed [SAMPLE_BITS-1:0] ring_q [WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] rd_q;
	logic [AW-1:0]  wr_q, rd_addr;
	logic [CB-1:0]  seen_q;
	logic [CB-1:0]  seen_n;
	logic signed [LB-1:0] lsum_q;
	logic [LW-1:0]  len, filled_q, quarter_q, k_q, kd_q;
	logic           rdv_q;
	logic signed [WSB-1:0] wsum_q, nsum_q, osum_q;
	logic signed [LB:0]    lnext;
	logic [LW-1:0]  filled_c;
	logic           div_done;
	logic signed [NB-1:0]  dnum;
	logic [CB-1:0]  dden;
	logic signed [wavg_pkg::AVG_BITS-1:0] dq;

	// count as it stands once the word being stored is included
	assign seen_n = (cmd.store && seen_q != '1) ? seen_q + 1'b1 : seen_q;

	always_comb begin
		if (wlen == '0) len = LW'(1);
		else if (wlen > wavg_pkg::WLEN_BITS'(WINDOW_MAX)) len = LW'(WINDOW_MAX);
		else len = wlen[LW-1:0];
		filled_c = (seen_n < CB'(len)) ? seen_n[LW-1:0] : len;
	end

	assign lnext = $signed({lsum_q[LB-1], lsum_q}) + (LB+1)'(sample);
	assign rd_addr = wr_q - AW'(1) - k_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.store) ring_q[wr_q] <= sample;
		rd_q <= ring_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; seen_q <= '0; lsum_q <= '0;
			filled_q <= '0; quarter_q <= '0; k_q <= '0; kd_q <= '0; rdv_q <= 1'b0;
			wsum_q <= '0; nsum_q <= '0; osum_q <= '0;
		end else begin
			rdv_q <= 1'b0;
			if (cmd.clear) begin
				wr_q <= '0; seen_q <= '0; lsum_q <= '0;
				filled_q <= '0; quarter_q <= '0;
				wsum_q <= '0; nsum_q <= '0; osum_q <= '0;
			end else if (cmd.store) begin
				wr_q <= wr_q + 1'b1;
				if (seen_q != '1) begin
					seen_q <= seen_q + 1'b1;
					if (lnext > $signed({1'b0, {(LB-1){1'b1}}, 1'b1}) >>> 1)
						lsum_q <= {1'b0, {(LB-1){1'b1}}};
					else if (lnext < -($signed({2'b01, {(LB-1){1'b0}}})))
						lsum_q <= {1'b1, {(LB-1){1'b0}}};
					else
						lsum_q <= lnext[LB-1:0];
				end
			end
			if (cmd.scan_start) begin
				filled_q <= filled_c;
				quarter_q <= (len < LW'(4) || seen_n < CB'(4)) ? LW'(0) : (filled_c >> 2);
				k_q <= '0;
				wsum_q <= '0; nsum_q <= '0; osum_q <= '0;
			end else if (cmd.scan_step) begin
				if (k_q < filled_q) begin
					k_q <= k_q + 1'b1;
					kd_q <= k_q;
					rdv_q <= 1'b1;
				end
			end
			if (rdv_q) begin
				wsum_q <= wsum_q + WSB'(rd_q);
				if (kd_q < quarter_q) nsum_q <= nsum_q + WSB'(rd_q);
				if (kd_q >= filled_q - quarter_q) osum_q <= osum_q + WSB'(rd_q);
			end
		end
	end

	assign status.scan_done = cmd.scan_step && (k_q >= filled_q) && !rdv_q;
	assign status.div_done  = div_done;

	always_comb begin
		case (cmd.div_sel)
			2'd0: begin dnum = NB'(wsum_q) <<< 8; dden = CB'(filled_q); end
			2'd1: begin dnum = NB'(lsum_q) <<< 8; dden = seen_q; end
			2'd2: begin dnum = NB'(nsum_q) <<< 8; dden = CB'(quarter_q); end
			default: begin dnum = NB'(osum_q) <<< 8; dden = CB'(quarter_q); end
		endcase
	end

	wavg_divider #(.NUM_BITS(NB), .DEN_BITS(CB)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(dnum), .den(dden), .done(div_done), .quot(dq)
	);

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			window_avg <= '0; lifetime_avg <= '0;
			newest_quarter_avg <= '0; oldest_quarter_avg <= '0;
		end else if (cmd.div_capture) begin
			case (cmd.div_sel)
				2'd0: window_avg <= dq;
				2'd1: lifetime_avg <= dq;
				2'd2: newest_quarter_avg <= dq;
				default: oldest_quarter_avg <= dq;
			endcase
		end
	end
endmodule

// ===== rtl/core/wavg_ctrl.sv =====
// wavg_ctrl: sequencer for clear, store, window scan and four divisions
// depends on wavg_pkg
module wavg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	output logic              out_valid,
	input  logic              out_ready,
	input  wavg_pkg::status_t status,
	output wavg_pkg::cmd_t    cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DIV0 = 3'd2;
	localparam logic [2:0] S_DIVW = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;
	logic [1:0] sel_q;
	logic       acc;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.div_sel = sel_q;
		cmd.clear = acc && (operation == wavg_pkg::OP_CLEAR);
		cmd.store = acc && (operation == wavg_pkg::OP_ADD);
		cmd.scan_start = cmd.store;
		cmd.scan_step  = (state_q == S_SCAN);
		cmd.div_start  = (state_q == S_DIV0);
		cmd.div_capture = (state_q == S_DIVW) && status.div_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (acc) state_q <= cmd.clear ? S_OUT : S_SCAN;
				S_SCAN: if (status.scan_done) begin
					state_q <= S_DIV0;
					sel_q <= '0;
				end
				S_DIV0: state_q <= S_DIVW;
				S_DIVW: if (status.div_done) begin
					sel_q <= sel_q + 1'b1;
					state_q <= (sel_q == 2'd3) ? S_OUT : S_DIV0;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== dv/window_average_with_quarter_sums_tb.sv =====
`timescale 1ns / 100ps
// window_average_with_quarter_sums_tb: self-checking bench for the window average block
// predicts the four Q.8 averages per word with a scoreboard class; depends on wavg_pkg
// and window_average_with_quarter_sums
module window_average_with_quarter_sums_tb;

	typedef struct {
		logic signed [wavg_pkg::AVG_BITS-1:0] win;
		logic signed [wavg_pkg::AVG_BITS-1:0] life;
		logic signed [wavg_pkg::AVG_BITS-1:0] newest;
		logic signed [wavg_pkg::AVG_BITS-1:0] oldest;
	} averages_t;

	class average_scoreboard;
		averages_t pending_avgs[$];
		int ring[wavg_pkg::WINDOW_MAX];
		int wr_pos;
		longint unsigned seen;
		longint life_sum;
		int unsigned wlen = wavg_pkg::WLEN_RESET;
		int mismatches;
		int checked;

		function void set_length(logic [31:0] v);
			wlen = v & 32'hFFFF;
		endfunction

		function logic signed [wavg_pkg::AVG_BITS-1:0] q8(longint sum, longint d);
			longint r;
			if (d == 0) return '0;
			r = (sum * 256) / d;
			if (r > 64'sh7FFFFF) r = 64'sh7FFFFF;
			if (r < -64'sh800000) r = -64'sh800000;
			return r[wavg_pkg::AVG_BITS-1:0];
		endfunction

		function void note_input(logic op, logic signed [wavg_pkg::SAMPLE_BITS-1:0] s);
			averages_t a;
			int unsigned len, filled, qsz;
			longint wsum, nsum, osum;
			int v;
			if (op == wavg_pkg::OP_CLEAR) begin
				wr_pos = 0;
				seen = 0;
				life_sum = 0;
				a = '{'0, '0, '0, '0};
				pending_avgs.push_back(a);
				return;
			end
			ring[wr_pos] = s;
			wr_pos = (wr_pos + 1) % wavg_pkg::WINDOW_MAX;
			if (seen < 64'hFFFF_FFFF) begin
				seen++;
				life_sum += s;
				if (life_sum > 64'sh7FFF_FFFF_FFFF) life_sum = 64'sh7FFF_FFFF_FFFF;
				if (life_sum < -64'sh8000_0000_0000) life_sum = -64'sh8000_0000_0000;
			end
			len = (wlen < 1) ? 1 : (wlen > wavg_pkg::WINDOW_MAX) ? wavg_pkg::WINDOW_MAX : wlen;
			filled = (seen < len) ? seen : len;
			qsz = (len < 4 || seen < 4) ? 0 : filled / 4;
			wsum = 0;
			nsum = 0;
			osum = 0;
			for (int unsigned k = 0; k < filled; k++) begin
				v = ring[(wr_pos + wavg_pkg::WINDOW_MAX - 1 - k) % wavg_pkg::WINDOW_MAX];
				wsum += v;
				if (k < qsz) nsum += v;
				if (k >= filled - qsz) osum += v;
			end
			a.win = q8(wsum, filled);
			a.life = q8(life_sum, seen);
			a.newest = q8(nsum, qsz);
			a.oldest = q8(osum, qsz);
			pending_avgs.push_back(a);
		endfunction

		function void check_result(averages_t got);
			averages_t e;
			checked++;
			if (pending_avgs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("error: unexpected result word");
				return;
			end
			e = pending_avgs.pop_front();
			if (got.win !== e.win || got.life !== e.life || got.newest !== e.newest ||
					got.oldest !== e.oldest) begin
				mismatches++;
				if (mismatches <= 10)
					$display("error: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
						e.win, e.life, e.newest, e.oldest,
						got.win, got.life, got.newest, got.oldest);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = wavg_pkg::OP_ADD;
	logic signed [wavg_pkg::SAMPLE_BITS-1:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [wavg_pkg::AVG_BITS-1:0] window_avg, lifetime_avg;
	logic signed [wavg_pkg::AVG_BITS-1:0] newest_quarter_avg, oldest_quarter_avg;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	average_scoreboard sb = new();
	longint cycles = 0;
	int words_sent = 0;

	window_average_with_quarter_sums u_dut (.*);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 10000000) begin
			$display("FAIL window_average_with_quarter_sums");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result('{window_avg, lifetime_avg, newest_quarter_avg,
					oldest_quarter_avg});
			if (in_valid && in_ready) begin
				sb.note_input(operation, sample);
				words_sent++;
			end
			if (psel && penable && pwrite && pready &&
					paddr == 2'(wavg_pkg::REG_WINDOW_LENGTH * 4))
				sb.set_length(pwdata);
		end
	end

	// receiver: switches at random between free-run and random stall, plus one long hold-off
	initial begin
		int hold;
		int mode;
		hold = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (cycles == 30000) hold = 3000;
			if (cycles % 64 == 0) mode = $urandom_range(0, 2);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else
				out_ready <= (mode == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_word(logic op, logic signed [wavg_pkg::SAMPLE_BITS-1:0] s);
		in_valid <= 1'b1;
		operation <= op;
		sample <= s;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic gap(int n);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		gap(1);
		while (sb.pending_avgs.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_length(logic [31:0] v);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= 2'(wavg_pkg::REG_WINDOW_LENGTH * 4);
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic signed [wavg_pkg::SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return wavg_pkg::SAMPLE_BITS'($signed($urandom_range(0, 15)) - 8);
			default: return wavg_pkg::SAMPLE_BITS'($urandom());
		endcase
	endfunction

	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 40);
			while (burst > 0 && n > 0) begin
				send_word(($urandom_range(0, 49) == 0) ? wavg_pkg::OP_CLEAR : wavg_pkg::OP_ADD,
					pick_sample());
				burst--;
				n--;
			end
			gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
		end
	endtask

	initial begin
		logic [31:0] lengths[10] = '{32'd1, 32'd0, 32'd4, 32'd3, 32'd256, 32'd65535,
			32'd300, 32'h0001_0008, 32'd7, 32'd16};
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_word(wavg_pkg::OP_CLEAR, 16'sh7FFF);
		repeat (5) send_word(wavg_pkg::OP_ADD, 16'sh7FFF);
		repeat (5) send_word(wavg_pkg::OP_ADD, 16'sh8000);
		send_word(wavg_pkg::OP_ADD, 16'sh0000);
		send_word(wavg_pkg::OP_ADD, 16'sh0001);
		send_word(wavg_pkg::OP_ADD, 16'shFFFF);
		send_word(wavg_pkg::OP_CLEAR, 16'sh1234);
		send_word(wavg_pkg::OP_ADD, -16'sd3);
		send_word(wavg_pkg::OP_ADD, 16'sd5);
		send_word(wavg_pkg::OP_ADD, -16'sd7);
		send_word(wavg_pkg::OP_ADD, 16'sd1);
		send_word(wavg_pkg::OP_ADD, 16'sh8000);
		drain();
		write_length(32'd5);
		repeat (3) send_word(wavg_pkg::OP_ADD, 16'sh7FFF);
		drain();

		random_phase(200);
		foreach (lengths[i]) begin
			drain();
			write_length(lengths[i]);
			random_phase((lengths[i] == 32'd256 || lengths[i] == 32'd65535 ||
				lengths[i] == 32'd300) ? 70 : 175);
			drain();
			write_length($urandom_range(2, 24));
			random_phase(20);
		end
		drain();
		while (sb.pending_avgs.size() != 0) @(negedge clk);
		repeat (600) @(negedge clk);

		$display("covered %0d input words, %0d results checked, window lengths 0 to 65535",
			words_sent, sb.checked);
		$display("long output hold-off and drain pauses between length changes included");
		if (sb.mismatches == 0 && sb.pending_avgs.size() == 0)
			$display("PASS window_average_with_quarter_sums");
		else
			$display("FAIL window_average_with_quarter_sums");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/core/wavg_pkg.sv
rtl/core/wavg_divider.sv
rtl/core/wavg_datapath.sv
rtl/core/wavg_ctrl.sv
rtl/core/window_average_with_quarter_sums.sv
dv/window_average_with_quarter_sums_tb.sv
